/* hw/rtl/vcp_pkg.sv */
package vcp_pkg;

  localparam int unsigned KeyMaxChars = 16;
  localparam int unsigned KeyPosW     = 4;
  localparam int unsigned KeyLenW     = 5;
  localparam int unsigned CfgDataW    = 64;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned IdxW        = 7;

  // Alphabet size; also the "not in alphabet" marker from alpha_index
  localparam logic [IdxW-1:0] AlphaSize = 7'd100;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgDecryptMode = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgKeyLength   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgKeyCharsLo  = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgKeyCharsHi  = 2'd3;

  // Byte to alphabet index; AlphaSize when the byte is outside the alphabet
  function automatic logic [IdxW-1:0] alpha_index(input logic [7:0] b);
    logic [7:0] t;
    t = 8'd100;
    case (b) inside
      [8'd48:8'd57]:   t = b - 8'd48;
      [8'd97:8'd122]:  t = b - 8'd87;
      [8'd65:8'd90]:   t = b - 8'd29;
      [8'd33:8'd47]:   t = b + 8'd29;
      [8'd58:8'd64]:   t = b + 8'd19;
      [8'd91:8'd96]:   t = b - 8'd7;
      [8'd123:8'd126]: t = b - 8'd33;
      8'd32:           t = 8'd94;
      8'd9:            t = 8'd95;
      8'd10:           t = 8'd96;
      8'd13:           t = 8'd97;
      8'd11:           t = 8'd98;
      8'd12:           t = 8'd99;
      default:         t = 8'd100;
    endcase
    return t[IdxW-1:0];
  endfunction

  // Alphabet index to byte; only indexes below AlphaSize are meaningful
  function automatic logic [7:0] alpha_char(input logic [IdxW-1:0] i);
    logic [7:0] w;
    logic [7:0] c;
    w = {1'b0, i};
    c = 8'd0;
    case (i) inside
      [7'd0:7'd9]:   c = w + 8'd48;
      [7'd10:7'd35]: c = w + 8'd87;
      [7'd36:7'd61]: c = w + 8'd29;
      [7'd62:7'd76]: c = w - 8'd29;
      [7'd77:7'd83]: c = w - 8'd19;
      [7'd84:7'd89]: c = w + 8'd7;
      [7'd90:7'd93]: c = w + 8'd33;
      7'd94:         c = 8'd32;
      7'd95:         c = 8'd9;
      7'd96:         c = 8'd10;
      7'd97:         c = 8'd13;
      7'd98:         c = 8'd11;
      7'd99:         c = 8'd12;
      default:       c = 8'd0;
    endcase
    return c;
  endfunction

endpackage

/* hw/rtl/vigenere_cipher_printable_top.sv */
// Vigenere byte cipher over a 100-character alphabet (digits, lower case,
// upper case, the 32 ASCII punctuation marks, then space, tab, LF, CR, VT,
// FF). One byte per transfer in, one byte per transfer out, in order. The
// block sustains one byte per clock while the output is not stalled: a
// transfer can be taken every cycle, and each byte passes an input stage
// that looks up the alphabet indexes of the byte and of the current key
// character, then a result stage that does the modulo-100 add or subtract
// and maps back to a byte. A byte is registered in the input stage and then
// in the result stage, whose valid flag is out_valid. The key
// position steps for every byte, wraps at key_length (0 acts as 1, above 16
// as 16) and returns to 0 after a byte marked last_of_message. Bytes outside
// the alphabet pass through unchanged with in_alphabet low; key characters
// outside the alphabet act as a shift of 0. Configuration writes take effect
// at once and must only be made while no byte is in flight.
module vigenere_cipher_printable_top
  import vcp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  // message bytes in
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          in_char_i,
  input  logic                last_of_message_i,
  // cipher bytes out
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          out_char_o,
  output logic                in_alphabet_o,
  output logic                last_o
);

  // ---------------- configuration registers ----------------
  logic                decrypt_q;
  logic [KeyLenW-1:0]  key_len_q;
  logic [CfgDataW-1:0] key_lo_q, key_hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decrypt_q <= 1'b0;
      key_len_q <= KeyLenW'(1);
      key_lo_q  <= '0;
      key_hi_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgDecryptMode: decrypt_q <= cfg_wdata_i[0];
        CfgKeyLength:   key_len_q <= cfg_wdata_i[KeyLenW-1:0];
        CfgKeyCharsLo:  key_lo_q  <= cfg_wdata_i;
        CfgKeyCharsHi:  key_hi_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ---------------- pipeline handshake ----------------
  logic s1_valid_q, s2_valid_q;
  logic s2_take, s1_take, in_xfer;

  assign s2_take    = !s2_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s2_take;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign s1_take    = s1_valid_q && s2_take;

  // ---------------- key position ----------------
  logic [KeyPosW-1:0] key_pos_q, key_pos_d, pos_eff;
  logic [KeyLenW-1:0] len_eff, pos_inc;

  always_comb begin
    // clamp the configured length into 1..KeyMaxChars
    len_eff = key_len_q;
    if (key_len_q == '0) begin
      len_eff = KeyLenW'(1);
    end
    if (key_len_q > KeyLenW'(KeyMaxChars)) begin
      len_eff = KeyLenW'(KeyMaxChars);
    end
    // length may have been lowered under a running position
    pos_eff = key_pos_q;
    if ({1'b0, key_pos_q} >= len_eff) begin
      pos_eff = '0;
    end
    pos_inc   = {1'b0, pos_eff} + KeyLenW'(1);
    key_pos_d = key_pos_q;
    if (in_xfer) begin
      if (last_of_message_i || pos_inc >= len_eff) begin
        key_pos_d = '0;
      end else begin
        key_pos_d = pos_inc[KeyPosW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_pos_q <= '0;
    end else begin
      key_pos_q <= key_pos_d;
    end
  end

  // ---------------- stage 1: index lookups ----------------
  logic [2*CfgDataW-1:0] key_all;
  logic [7:0]            key_byte;
  logic [IdxW-1:0]       key_idx_raw;
  logic [IdxW-1:0]       msg_idx_d, key_idx_d;
  logic [IdxW-1:0]       msg_idx_q, key_idx_q;
  logic [7:0]            s1_char_q;
  logic                  s1_last_q;

  assign key_all     = {key_hi_q, key_lo_q};
  assign key_byte    = key_all[{pos_eff, 3'b000} +: 8];
  assign key_idx_raw = alpha_index(key_byte);
  assign key_idx_d   = (key_idx_raw == AlphaSize) ? '0 : key_idx_raw;
  assign msg_idx_d   = alpha_index(in_char_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      msg_idx_q <= msg_idx_d;
      key_idx_q <= key_idx_d;
      s1_char_q <= in_char_i;
      s1_last_q <= last_of_message_i;
    end
  end

  // ---------------- stage 2: modular shift and map back ----------------
  logic [7:0]      sum;
  logic [IdxW-1:0] res_idx;
  logic            in_alpha;
  logic [7:0]      out_char_d, out_char_q;
  logic            in_alpha_q, last_q;

  assign in_alpha = (msg_idx_q != AlphaSize);

  always_comb begin
    if (decrypt_q) begin
      sum = {1'b0, msg_idx_q} + 8'd100 - {1'b0, key_idx_q};
    end else begin
      sum = {1'b0, msg_idx_q} + {1'b0, key_idx_q};
    end
    // for alphabet bytes sum stays below 200, so one conditional subtract wraps it
    if (sum >= 8'd100) begin
      sum = sum - 8'd100;
    end
    res_idx    = sum[IdxW-1:0];
    out_char_d = in_alpha ? alpha_char(res_idx) : s1_char_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_take) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_take) begin
      out_char_q <= out_char_d;
      in_alpha_q <= in_alpha;
      last_q     <= s1_last_q;
    end
  end

  assign out_valid_o   = s2_valid_q;
  assign out_char_o    = out_char_q;
  assign in_alphabet_o = in_alpha_q;
  assign last_o        = last_q;

endmodule

/* hw/rtl/vcp_checker.sv */
module vcp_checker
  import vcp_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic [7:0]          out_char_o,
  input logic                in_alphabet_o,
  input logic                last_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_char_o)
      && $stable(in_alphabet_o) && $stable(last_o))
    else $error("stalled result changed");

  // a free output side never blocks the input
  a_no_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || out_ready_i) |-> in_ready_o)
    else $error("input stalled with output free");

  // transformed bytes stay in the alphabet
  a_in_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && in_alphabet_o |-> alpha_index(out_char_o) != AlphaSize)
    else $error("cipher byte outside alphabet");

  // passed-through bytes are never alphabet characters
  a_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !in_alphabet_o |-> alpha_index(out_char_o) == AlphaSize)
    else $error("alphabet byte passed through");

endmodule

bind vigenere_cipher_printable_top vcp_checker u_vcp_checker (.*);

/* tb/sv/vcp_stream_checker.sv */
module vcp_stream_checker
  import vcp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [7:0]          in_char_i,
  input  logic                last_of_message_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [7:0]          out_char_i,
  input  logic                in_alphabet_i,
  input  logic                last_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o
);

  localparam int unsigned AlphaN = 100;

  typedef struct packed {
    logic [7:0] ch;
    logic       alpha;
    logic       last;
  } cipher_out_t;

  logic [7:0]          alpha_tab [AlphaN];
  cipher_out_t         cipher_q [$];
  logic                decrypt_q;
  logic [KeyLenW-1:0]  key_len_q;
  logic [63:0]         key_lo_q;
  logic [63:0]         key_hi_q;
  int unsigned         key_pos_q;
  int unsigned         fails;

  // alphabet order: digits, lower, upper, punctuation, then the whitespace set
  initial begin : build_alphabet
    int unsigned n;
    n = 0;
    for (int c = 48; c <= 57; c++) begin alpha_tab[n] = 8'(c); n++; end
    for (int c = 97; c <= 122; c++) begin alpha_tab[n] = 8'(c); n++; end
    for (int c = 65; c <= 90; c++) begin alpha_tab[n] = 8'(c); n++; end
    for (int c = 33; c <= 126; c++) begin
      if (!((c >= 48 && c <= 57) || (c >= 65 && c <= 90) || (c >= 97 && c <= 122))) begin
        alpha_tab[n] = 8'(c);
        n++;
      end
    end
    alpha_tab[94] = 8'd32;
    alpha_tab[95] = 8'd9;
    alpha_tab[96] = 8'd10;
    alpha_tab[97] = 8'd13;
    alpha_tab[98] = 8'd11;
    alpha_tab[99] = 8'd12;
  end

  function automatic int unsigned index_of(input logic [7:0] b);
    for (int i = 0; i < AlphaN; i++) begin
      if (alpha_tab[i] == b) return i;
    end
    return AlphaN;
  endfunction

  function automatic int unsigned key_span();
    if (key_len_q == 0) return 1;
    if (key_len_q > KeyMaxChars) return KeyMaxChars;
    return key_len_q;
  endfunction

  function automatic cipher_out_t cipher_byte(input logic [7:0] ch, input logic lst,
                                              input int unsigned pos);
    cipher_out_t r;
    int unsigned mi;
    int unsigned ki;
    logic [7:0]  kb;
    r.ch    = ch;
    r.alpha = 1'b0;
    r.last  = lst;
    mi = index_of(ch);
    if (mi < AlphaN) begin
      if (pos < 8) begin
        kb = key_lo_q[8*pos +: 8];
      end else begin
        kb = key_hi_q[8*(pos-8) +: 8];
      end
      ki = index_of(kb);
      if (ki >= AlphaN) ki = 0;  // non-alphabet key char: no shift
      mi = decrypt_q ? (mi + AlphaN - ki) % AlphaN : (mi + ki) % AlphaN;
      r.ch    = alpha_tab[mi];
      r.alpha = 1'b1;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    cipher_out_t want;
    cipher_out_t got;
    int unsigned span;
    int unsigned pos;
    if (!rst_ni) begin
      decrypt_q = 1'b0;
      key_len_q = KeyLenW'(1);
      key_lo_q  = '0;
      key_hi_q  = '0;
      key_pos_q = 0;
      fails     = 0;
      cipher_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = {out_char_i, in_alphabet_i, last_i};
        if (cipher_q.size() == 0) begin
          $error("out transfer with nothing outstanding: out_char %h", out_char_i);
          fails++;
        end else begin
          want = cipher_q.pop_front();
          if (got.ch !== want.ch) begin
            $error("out_char: expected %h, got %h", want.ch, got.ch);
            fails++;
          end
          if (got.alpha !== want.alpha) begin
            $error("in_alphabet: expected %b, got %b", want.alpha, got.alpha);
            fails++;
          end
          if (got.last !== want.last) begin
            $error("last: expected %b, got %b", want.last, got.last);
            fails++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        span = key_span();
        pos  = key_pos_q;
        if (pos >= span) pos = 0;  // length lowered under a running position
        cipher_q.push_back(cipher_byte(in_char_i, last_of_message_i, pos));
        key_pos_q = (last_of_message_i || pos + 1 >= span) ? 0 : pos + 1;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgDecryptMode: decrypt_q = cfg_wdata_i[0];
          CfgKeyLength:   key_len_q = cfg_wdata_i[KeyLenW-1:0];
          CfgKeyCharsLo:  key_lo_q  = cfg_wdata_i;
          CfgKeyCharsHi:  key_hi_q  = cfg_wdata_i;
          default: ;
        endcase
      end
    end
    fail_count_o <= fails;
    pending_o    <= cipher_q.size();
  end

endmodule

/* tb/sv/tb_vigenere_cipher_printable_top.sv */
module tb_vigenere_cipher_printable_top;
  import vcp_pkg::*;

  localparam int unsigned RandItems   = 1100;
  localparam int unsigned HoldCycles  = 300;  // long receiver hold-off, fills the pipe
  localparam int unsigned DrainCycles = 8;    // drain margin after pending reaches zero
  localparam int unsigned MaxCycles   = 500000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [7:0]          in_char = '0;
  logic                in_last = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [7:0]          out_char;
  logic                out_alpha;
  logic                out_last;
  int unsigned         fail_count;
  int unsigned         pending;
  int unsigned         cycle_count = 0;

  // Idling controls shared between the sender and the receiver. A burst flag
  // removes all random gaps on that side for the current phase; hold_out asks
  // the receiver for one long hold-off.
  bit in_burst = 1'b0;
  bit out_burst = 1'b0;
  bit hold_out = 1'b0;

  vigenere_cipher_printable_top u_dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_idx_i         (cfg_idx),
    .cfg_wdata_i       (cfg_wdata),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .in_char_i         (in_char),
    .last_of_message_i (in_last),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .out_char_o        (out_char),
    .in_alphabet_o     (out_alpha),
    .last_o            (out_last)
  );

  vcp_stream_checker u_chk (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_idx_i         (cfg_idx),
    .cfg_wdata_i       (cfg_wdata),
    .in_valid_i        (in_valid),
    .in_ready_i        (in_ready),
    .in_char_i         (in_char),
    .last_of_message_i (in_last),
    .out_valid_i       (out_valid),
    .out_ready_i       (out_ready),
    .out_char_i        (out_char),
    .in_alphabet_i     (out_alpha),
    .last_i            (out_last),
    .fail_count_o      (fail_count),
    .pending_o         (pending)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= MaxCycles) begin
      $display("status: fail");
      $finish;
    end
  end

  // Mostly printable ASCII (all of which lies in the alphabet), some of the
  // whitespace controls, and a share of arbitrary bytes so every bit toggles.
  function automatic logic [7:0] rand_text_byte();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return 8'($urandom_range(32, 126));
    if (r < 7) return 8'($urandom_range(9, 13));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [63:0] rand_key_word();
    logic [63:0] w;
    if ($urandom_range(0, 7) == 0) return {$urandom, $urandom};
    for (int i = 0; i < 8; i++) w[8*i +: 8] = rand_text_byte();
    return w;
  endfunction

  // One byte transfer: optional idle gap, then hold valid until accepted.
  // With no gap, valid simply stays high for the next byte.
  task automatic send_byte(input logic [7:0] ch, input logic lst);
    int unsigned gap;
    gap = in_burst ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char  <= ch;
    in_last  <= lst;
    do @(posedge clk); while (!in_ready);
  endtask

  // A well-formed message ends on its last byte; a noisy one scatters the
  // last flag at random, so messages break off or run together.
  task automatic send_message(input int unsigned len, input bit noisy);
    for (int unsigned i = 0; i < len; i++) begin
      send_byte(rand_text_byte(), noisy ? ($urandom_range(0, 3) == 0) : (i == len - 1));
    end
  endtask

  // All four registers in one back-to-back burst of writes
  task automatic write_config(input logic dec, input logic [KeyLenW-1:0] len,
                              input logic [63:0] lo, input logic [63:0] hi);
    cfg_we    <= 1'b1;
    cfg_idx   <= CfgDecryptMode;
    cfg_wdata <= CfgDataW'(dec);
    @(posedge clk);
    cfg_idx   <= CfgKeyLength;
    cfg_wdata <= CfgDataW'(len);
    @(posedge clk);
    cfg_idx   <= CfgKeyCharsLo;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_idx   <= CfgKeyCharsHi;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Drop valid and wait for the pipe to empty. The extra edge first lets the
  // checker register the byte taken at this edge before pending is trusted.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Receiver: random stall per result, bursts with none, and one long
  // hold-off on request while the sender keeps offering bytes.
  initial begin : sink
    int unsigned stall;
    wait (rst_n);
    forever begin
      if (hold_out) begin
        hold_out = 1'b0;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else begin
        stall = out_burst ? 0 : $urandom_range(0, 16);
        if (stall != 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : stimulus
    int unsigned        sent;
    int unsigned        phase;
    int unsigned        quota;
    int unsigned        len;
    logic               dec;
    logic [KeyLenW-1:0] klen;
    logic [63:0]        lo;
    logic [63:0]        hi;
    sent  = 0;
    phase = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: key chars are all zero bytes, outside the alphabet, so
    // every in-alphabet byte maps to itself. Extremes of the byte range plus
    // the first and last alphabet entries.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte("0", 1'b0);
    send_byte(8'h0C, 1'b1);
    settle();

    // Encrypt with key "z~<FF>": pushes high indexes past 99 and wraps
    write_config(1'b0, KeyLenW'(3), 64'h0000_0000_000C_7E7A, 64'h0);
    send_byte("~", 1'b0);
    send_byte(8'h0C, 1'b0);
    send_byte(" ", 1'b0);
    send_byte(8'h09, 1'b0);
    send_byte(8'h7F, 1'b1);
    settle();

    // Decrypt, same key: low indexes go below zero and wrap
    write_config(1'b1, KeyLenW'(3), 64'h0000_0000_000C_7E7A, 64'h0);
    send_byte("0", 1'b0);
    send_byte("1", 1'b1);
    settle();

    // Full-length key mixing alphabet chars with NUL, DEL and high bytes;
    // stop mid-message at position 9, then shrink the length under it
    lo = 64'hFF80_007F_2120_7A30;
    hi = 64'h4847_4645_4443_4241;
    write_config(1'b0, KeyLenW'(16), lo, hi);
    for (int i = 0; i < 9; i++) send_byte(8'h61 + 8'(i), 1'b0);
    settle();
    write_config(1'b0, KeyLenW'(3), lo, hi);
    send_byte("x", 1'b0);
    send_byte("~", 1'b1);
    settle();

    // Out-of-range lengths: zero acts as one, above sixteen as sixteen
    write_config(1'b0, KeyLenW'(0), lo, hi);
    send_byte("5", 1'b0);
    send_byte("5", 1'b1);
    settle();
    write_config(1'b1, KeyLenW'(31), lo, hi);
    send_byte("Q", 1'b0);
    send_byte(8'h0B, 1'b1);
    settle();

    // Random phases: fresh settings each time, then a run of messages. The
    // first two phases pin the length extremes; the third carries the long
    // receiver hold-off with the sender flat out.
    while (sent < RandItems) begin
      case (phase)
        0: begin
          dec  = 1'b0;
          klen = KeyLenW'(16);
        end
        1: begin
          dec  = 1'b1;
          klen = KeyLenW'(1);
        end
        default: begin
          dec  = 1'($urandom_range(0, 1));
          klen = ($urandom_range(0, 3) == 0) ? KeyLenW'($urandom_range(0, 31))
                                             : KeyLenW'($urandom_range(1, 16));
        end
      endcase
      write_config(dec, klen, rand_key_word(), rand_key_word());
      in_burst  = ($urandom_range(0, 3) == 0);
      out_burst = ($urandom_range(0, 3) == 0);
      if (phase == 2) begin
        hold_out = 1'b1;
        in_burst = 1'b1;
      end
      quota = $urandom_range(40, 120);
      while (quota > 0) begin
        len = $urandom_range(1, 20);
        send_message(len, $urandom_range(0, 7) == 0);
        sent  += len;
        quota  = (len >= quota) ? 0 : quota - len;
      end
      settle();
      phase++;
    end

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
